### sv/gcd_pkg.sv
// Shared types and constants for the binary glTF container deframer.
package gcd_pkg;

   // Container constants, little-endian on the wire.
   localparam logic [31:0] GLB_MAGIC   = 32'h4654_6C67;
   localparam logic [7:0]  GLB_VERSION = 8'd2;
   localparam logic [31:0] TYPE_JSON   = 32'h4E4F_534A;
   localparam logic [31:0] TYPE_BIN    = 32'h004E_4942;

   // Byte class codes.
   localparam logic [2:0] CLS_FILE_HDR  = 3'd0;
   localparam logic [2:0] CLS_CHUNK_HDR = 3'd1;
   localparam logic [2:0] CLS_JSON      = 3'd2;
   localparam logic [2:0] CLS_BIN       = 3'd3;
   localparam logic [2:0] CLS_PAD       = 3'd4;
   localparam logic [2:0] CLS_DISCARD   = 3'd5;

   // Status codes.
   localparam logic [3:0] ST_RUNNING     = 4'd0;
   localparam logic [3:0] ST_OK          = 4'd1;
   localparam logic [3:0] ST_TOO_SHORT   = 4'd2;
   localparam logic [3:0] ST_BAD_MAGIC   = 4'd3;
   localparam logic [3:0] ST_BAD_VERSION = 4'd4;
   localparam logic [3:0] ST_DUP_JSON    = 4'd5;
   localparam logic [3:0] ST_DUP_BIN     = 4'd6;
   localparam logic [3:0] ST_UNKNOWN     = 4'd7;
   localparam logic [3:0] ST_NO_JSON     = 4'd8;
   localparam logic [3:0] ST_NO_BIN      = 4'd9;
   localparam logic [3:0] ST_TRUNCATED   = 4'd10;

   // One result beat as it passes from the parser to the output register.
   typedef struct packed {
      logic [7:0] byte_out;
      logic [2:0] byte_class;
      logic [3:0] status;
      logic       frame_end;
   } result_type;

endpackage

### sv/gcd_parse.sv
// Parser state and per-byte classification for the container deframer.
module gcd_parse (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [7:0]         data_byte,
   input  logic               end_of_file,
   output gcd_pkg::result_type result
);
   import gcd_pkg::*;

   typedef enum logic [2:0] {
      PH_HDR  = 3'd0,
      PH_CHDR = 3'd1,
      PH_JSON = 3'd2,
      PH_BIN  = 3'd3,
      PH_PAD  = 3'd4
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  count_ff, count_in;
   logic        magic_ff, magic_in;
   logic        version_ff, version_in;
   logic [31:0] length_ff, length_in;
   logic [31:0] type_ff, type_in;
   logic [31:0] payload_ff, payload_in;
   logic [1:0]  padding_ff, padding_in;
   logic        seen_json_ff, seen_json_in;
   logic        seen_bin_ff, seen_bin_in;
   logic [3:0]  error_ff, error_in;

   logic [2:0]  cls;
   logic [3:0]  status;
   logic [7:0]  magic_byte;
   logic [7:0]  version_byte;
   logic [31:0] type_word;
   logic [1:0]  pad_for_len;
   logic        enter;
   phase_type   enter_phase;

   // Expected header bytes for the current header position.
   assign magic_byte   = GLB_MAGIC[{count_ff[1:0], 3'b000} +: 8];
   assign version_byte = (count_ff == 4'd4) ? GLB_VERSION : 8'd0;
   assign type_word    = {data_byte, type_ff[31:8]};
   assign pad_for_len  = 2'd0 - length_ff[1:0];

   // Next-state logic for one accepted byte.
   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      magic_in     = magic_ff;
      version_in   = version_ff;
      length_in    = length_ff;
      type_in      = type_ff;
      payload_in   = payload_ff;
      padding_in   = padding_ff;
      seen_json_in = seen_json_ff;
      seen_bin_in  = seen_bin_ff;
      error_in     = error_ff;
      cls          = CLS_DISCARD;
      enter        = 1'b0;
      enter_phase  = PH_JSON;

      if (error_ff == ST_RUNNING) begin
         unique case (phase_ff)
            PH_HDR: begin
               cls = CLS_FILE_HDR;
               if (count_ff < 4'd4) begin
                  if (data_byte != magic_byte) magic_in = 1'b0;
               end else if (count_ff < 4'd8) begin
                  if (data_byte != version_byte) version_in = 1'b0;
               end
               if (count_ff >= 4'd11) begin
                  if (!magic_in) error_in = ST_BAD_MAGIC;
                  else if (!version_in) error_in = ST_BAD_VERSION;
                  phase_in = PH_CHDR;
                  count_in = 4'd0;
               end else begin
                  count_in = count_ff + 4'd1;
               end
            end
            PH_CHDR: begin
               cls = CLS_CHUNK_HDR;
               if (count_ff < 4'd4) length_in = {data_byte, length_ff[31:8]};
               else type_in = type_word;
               if (count_ff >= 4'd7) begin
                  if (type_word == TYPE_JSON) begin
                     if (seen_json_ff) error_in = ST_DUP_JSON;
                     else begin
                        seen_json_in = 1'b1;
                        enter        = 1'b1;
                        enter_phase  = PH_JSON;
                     end
                  end else if (type_word == TYPE_BIN) begin
                     if (seen_bin_ff) error_in = ST_DUP_BIN;
                     else begin
                        seen_bin_in = 1'b1;
                        enter       = 1'b1;
                        enter_phase = PH_BIN;
                     end
                  end else begin
                     error_in = ST_UNKNOWN;
                  end
               end else begin
                  count_in = count_ff + 4'd1;
               end
            end
            PH_JSON, PH_BIN: begin
               cls        = (phase_ff == PH_JSON) ? CLS_JSON : CLS_BIN;
               payload_in = payload_ff - 32'd1;
               if (payload_ff == 32'd1) begin
                  phase_in = (padding_ff != 2'd0) ? PH_PAD : PH_CHDR;
               end
            end
            PH_PAD: begin
               cls        = CLS_PAD;
               padding_in = padding_ff - 2'd1;
               if (padding_ff == 2'd1) phase_in = PH_CHDR;
            end
            default: begin
               cls = CLS_DISCARD;
            end
         endcase
      end

      // Start of a chunk payload, or straight to padding or the next header.
      if (enter) begin
         payload_in = length_ff;
         padding_in = pad_for_len;
         count_in   = 4'd0;
         if (length_ff != 32'd0) phase_in = enter_phase;
         else if (pad_for_len != 2'd0) phase_in = PH_PAD;
         else phase_in = PH_CHDR;
      end
   end

   // Final status on the last byte, sticky error code otherwise.
   always_comb begin
      status = error_in;
      if (end_of_file && error_in == ST_RUNNING) begin
         if (phase_in == PH_HDR) status = ST_TOO_SHORT;
         else if (phase_in == PH_CHDR && count_in == 4'd0) begin
            if (!seen_json_in) status = ST_NO_JSON;
            else if (!seen_bin_in) status = ST_NO_BIN;
            else status = ST_OK;
         end else status = ST_TRUNCATED;
      end
   end

   assign result.byte_out   = data_byte;
   assign result.byte_class = cls;
   assign result.status     = status;
   assign result.frame_end  = end_of_file;

   // Parser state, cleared by reset and after the last byte of each file.
   always_ff @(posedge clock) begin
      if (reset || (advance && end_of_file)) begin
         phase_ff     <= PH_HDR;
         count_ff     <= 4'd0;
         magic_ff     <= 1'b1;
         version_ff   <= 1'b1;
         length_ff    <= 32'd0;
         type_ff      <= 32'd0;
         payload_ff   <= 32'd0;
         padding_ff   <= 2'd0;
         seen_json_ff <= 1'b0;
         seen_bin_ff  <= 1'b0;
         error_ff     <= ST_RUNNING;
      end else if (advance) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         magic_ff     <= magic_in;
         version_ff   <= version_in;
         length_ff    <= length_in;
         type_ff      <= type_in;
         payload_ff   <= payload_in;
         padding_ff   <= padding_in;
         seen_json_ff <= seen_json_in;
         seen_bin_ff  <= seen_bin_in;
         error_ff     <= error_in;
      end
   end

endmodule

### sv/gcd_out_reg.sv
// Result register that holds one beat for the result channel.
module gcd_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  gcd_pkg::result_type result,
   output logic                load_ok,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output gcd_pkg::result_type held
);
   import gcd_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   // A new beat may enter when the register is empty or being drained.
   assign load_ok    = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign held       = data_ff;

   // Valid flag tracks loads and drains.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

endmodule

### sv/glb_container_deframer_unit.sv
// Top level of the binary glTF container deframer.
//
// The req channel takes one file byte per beat in tdata, with tlast on the
// last byte of the file; the byte after it begins a new file. The rsp
// channel returns exactly one beat per input beat, in order: the byte, its
// class in tuser, the status code, and tlast on the file's last byte, where
// the status is final. On other beats status is the sticky error, or zero.
// An input register feeds short parsing logic that fills a result register,
// so the result beat for a byte passes through the input register and then
// the result register before it is presented on rsp.
// One byte is taken every cycle while the receiver takes results; the rate
// is set by the single parser state update per byte.
// Reset (synchronous, active high) empties both registers and returns the
// parser to the start of a file. When rsp_tready is low the result register
// holds its beat, the input register fills behind it, and req_tready then
// drops until the result drains; no beat is lost or repeated.
module glb_container_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_file
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] byte_out, [11:8] status, [15:12] zero
   output logic [2:0]  rsp_tuser,   // [2:0] byte_class
   output logic        rsp_tlast    // frame_end
);
   import gcd_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       load_ok;
   logic       advance;
   result_type result;
   result_type held;

   // Move a beat from the input register into the result register.
   assign advance    = in_valid_ff && load_ok;
   assign req_tready = !in_valid_ff || advance;

   // Input register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   gcd_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .data_byte   (in_byte_ff),
      .end_of_file (in_last_ff),
      .result      (result)
   );

   gcd_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .load_ok    (load_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .held       (held)
   );

   // Pack the result beat onto the rsp ports.
   assign rsp_tdata = {4'd0, held.status, held.byte_out};
   assign rsp_tuser = held.byte_class;
   assign rsp_tlast = held.frame_end;

endmodule

### tb/glb_container_deframer_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the binary glTF container deframer: directed and random files.
module glb_container_deframer_unit_tb;
   import gcd_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 60;
   localparam int PHASE_BEATS    = 270;

   // Parser phases of the predictor.
   localparam logic [2:0] PARSE_FILE_HDR  = 3'd0;
   localparam logic [2:0] PARSE_CHUNK_HDR = 3'd1;
   localparam logic [2:0] PARSE_JSON      = 3'd2;
   localparam logic [2:0] PARSE_BIN       = 3'd3;
   localparam logic [2:0] PARSE_PAD       = 3'd4;

   // Predicts the result of every accepted byte and checks the result beats in order.
   class deframer_checker;
      logic [2:0]  phase;
      logic [3:0]  field_count;
      bit          magic_ok;
      bit          version_ok;
      logic [31:0] length_word;
      logic [31:0] type_word;
      logic [31:0] payload_left;
      logic [1:0]  pad_left;
      bit          seen_json;
      bit          seen_bin;
      logic [3:0]  sticky_err;
      result_type  pending_results[$];
      int unsigned beat_no;
      int unsigned errors;

      function new();
         clear_parse();
         beat_no = 0;
         errors = 0;
      endfunction

      // State at the start of every file.
      function void clear_parse();
         phase = PARSE_FILE_HDR;
         field_count = 4'd0;
         magic_ok = 1'b1;
         version_ok = 1'b1;
         length_word = 32'd0;
         type_word = 32'd0;
         payload_left = 32'd0;
         pad_left = 2'd0;
         seen_json = 1'b0;
         seen_bin = 1'b0;
         sticky_err = ST_RUNNING;
      endfunction

      // A chunk header is complete; an empty payload skips to padding or the next header.
      function void open_payload(logic [2:0] payload_phase);
         payload_left = length_word;
         pad_left = ~length_word[1:0] + 2'd1;
         field_count = 4'd0;
         if (payload_left != 32'd0) begin
            phase = payload_phase;
         end else if (pad_left != 2'd0) begin
            phase = PARSE_PAD;
         end else begin
            phase = PARSE_CHUNK_HDR;
         end
      endfunction

      function result_type parse_byte(logic [7:0] b, logic last);
         result_type r;
         logic [3:0] cnt;
         logic [7:0] want;
         cnt = field_count;
         r.byte_out = b;
         r.byte_class = CLS_DISCARD;
         r.frame_end = last;
         if (sticky_err == ST_RUNNING) begin
            case (phase)
               PARSE_FILE_HDR: begin
                  r.byte_class = CLS_FILE_HDR;
                  if (cnt < 4) begin
                     want = 8'(GLB_MAGIC >> (8 * cnt));
                     if (b != want) magic_ok = 1'b0;
                  end else if (cnt < 8) begin
                     want = (cnt == 4'd4) ? GLB_VERSION : 8'h00;
                     if (b != want) version_ok = 1'b0;
                  end
                  // Magic and version are judged together at the twelfth byte.
                  if (cnt >= 11) begin
                     if (!magic_ok) begin
                        sticky_err = ST_BAD_MAGIC;
                     end else if (!version_ok) begin
                        sticky_err = ST_BAD_VERSION;
                     end
                     phase = PARSE_CHUNK_HDR;
                     field_count = 4'd0;
                  end else begin
                     field_count = cnt + 4'd1;
                  end
               end
               PARSE_CHUNK_HDR: begin
                  r.byte_class = CLS_CHUNK_HDR;
                  if (cnt < 4) begin
                     length_word = {b, length_word[31:8]};
                  end else begin
                     type_word = {b, type_word[31:8]};
                  end
                  if (cnt >= 7) begin
                     if (type_word == TYPE_JSON) begin
                        if (seen_json) begin
                           sticky_err = ST_DUP_JSON;
                        end else begin
                           seen_json = 1'b1;
                           open_payload(PARSE_JSON);
                        end
                     end else if (type_word == TYPE_BIN) begin
                        if (seen_bin) begin
                           sticky_err = ST_DUP_BIN;
                        end else begin
                           seen_bin = 1'b1;
                           open_payload(PARSE_BIN);
                        end
                     end else begin
                        sticky_err = ST_UNKNOWN;
                     end
                  end else begin
                     field_count = cnt + 4'd1;
                  end
               end
               PARSE_JSON, PARSE_BIN: begin
                  r.byte_class = (phase == PARSE_JSON) ? CLS_JSON : CLS_BIN;
                  payload_left = payload_left - 32'd1;
                  if (payload_left == 32'd0) begin
                     phase = (pad_left != 2'd0) ? PARSE_PAD : PARSE_CHUNK_HDR;
                  end
               end
               PARSE_PAD: begin
                  r.byte_class = CLS_PAD;
                  pad_left = pad_left - 2'd1;
                  if (pad_left == 2'd0) phase = PARSE_CHUNK_HDR;
               end
               default: begin
                  r.byte_class = CLS_DISCARD;
               end
            endcase
         end

         // The last byte of a file carries the final verdict and restarts the parser.
         r.status = sticky_err;
         if (last) begin
            if (sticky_err != ST_RUNNING) begin
               r.status = sticky_err;
            end else if (phase == PARSE_FILE_HDR) begin
               r.status = ST_TOO_SHORT;
            end else if (phase == PARSE_CHUNK_HDR && field_count == 4'd0) begin
               r.status = !seen_json ? ST_NO_JSON : (!seen_bin ? ST_NO_BIN : ST_OK);
            end else begin
               r.status = ST_TRUNCATED;
            end
            clear_parse();
         end
         return r;
      endfunction

      function void note_input(logic [7:0] b, logic last);
         pending_results = {pending_results, parse_byte(b, last)};
      endfunction

      function int pending_count();
         return pending_results.size();
      endfunction

      task report(string what);
         $display("mismatch at result beat %0d: %s", beat_no, what);
         errors++;
      endtask

      task check_result(logic [15:0] tdata, logic [2:0] tuser, logic tlast);
         result_type want;
         beat_no++;
         if (pending_results.size() == 0) begin
            report("result beat with no byte outstanding");
            return;
         end
         want = pending_results.pop_front();
         if (tdata[7:0] !== want.byte_out) begin
            report($sformatf("byte_out got %0h want %0h", tdata[7:0], want.byte_out));
         end
         if (tdata[11:8] !== want.status) begin
            report($sformatf("status got %0d want %0d", tdata[11:8], want.status));
         end
         if (tdata[15:12] !== 4'd0) begin
            report($sformatf("tdata fill bits got %0h want 0", tdata[15:12]));
         end
         if (tuser !== want.byte_class) begin
            report($sformatf("byte_class got %0d want %0d", tuser, want.byte_class));
         end
         if (tlast !== want.frame_end) begin
            report($sformatf("frame_end got %0b want %0b", tlast, want.frame_end));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   int              tx_idle_pct = 0;
   int              rx_stall_pct = 0;
   bit              hold_request = 1'b0;
   int              idle_cycles = 0;
   deframer_checker board;
   logic [7:0]      file_q[$];

   glb_container_deframer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   // Note accepted bytes and check accepted results at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_input(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // Watchdog on cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[glb_container_deframer_unit] ERROR");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off on request.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   // Offer one byte, with random idle cycles ahead of it, and wait until it is accepted.
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata <= 8'($urandom());
         req_tlast <= 1'($urandom());
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_file();
      int i;
      for (i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
   endtask

   // Stop offering until every outstanding result has come back.
   task automatic pause_for_drain();
      req_tvalid <= 1'b0;
      while (board.pending_count() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic push_word(input logic [31:0] w);
      int i;
      for (i = 0; i < 4; i++) file_q = {file_q, w[8*i +: 8]};
   endtask

   task automatic push_chunk(input logic [31:0] ctype, input int unsigned n);
      push_word(n);
      push_word(ctype);
      repeat (n) file_q = {file_q, 8'($urandom())};
      repeat ((4 - (n % 4)) % 4) file_q = {file_q, 8'($urandom())};
   endtask

   // Mostly well-formed files with random content; some noise, bad headers,
   // odd chunk sets and truncation.
   task automatic build_random_file();
      int          kind;
      int          nchunks;
      int          cut;
      int          idx;
      int          i;
      int unsigned sz;
      logic [31:0] types[3];
      file_q.delete();
      kind = $urandom_range(99);
      if (kind < 8) begin
         repeat ($urandom_range(1, 20)) file_q = {file_q, 8'($urandom())};
         return;
      end
      push_word(GLB_MAGIC);
      push_word(32'(GLB_VERSION));
      push_word($urandom());
      if (kind < 16) begin
         idx = $urandom_range(7);
         file_q[idx] = file_q[idx] ^ (8'h01 << $urandom_range(7));
      end
      // A huge declared length that the file never reaches.
      if (kind < 21) begin
         push_word($urandom() | 32'h0100_0000);
         push_word(($urandom_range(1) == 1) ? TYPE_JSON : TYPE_BIN);
         repeat ($urandom_range(0, 6)) file_q = {file_q, 8'($urandom())};
         return;
      end
      if ($urandom_range(1) == 1) begin
         types[0] = TYPE_JSON;
         types[1] = TYPE_BIN;
      end else begin
         types[0] = TYPE_BIN;
         types[1] = TYPE_JSON;
      end
      case ($urandom_range(2))
         0:       types[2] = TYPE_JSON;
         1:       types[2] = TYPE_BIN;
         default: types[2] = $urandom();
      endcase
      if ($urandom_range(99) < 10) types[$urandom_range(2)] = $urandom();
      case ($urandom_range(9))
         0:       nchunks = 0;
         1, 2:    nchunks = 1;
         8, 9:    nchunks = 3;
         default: nchunks = 2;
      endcase
      if (nchunks == 1 && $urandom_range(1) == 1) types[0] = types[1];
      for (i = 0; i < nchunks; i++) begin
         sz = ($urandom_range(9) == 0) ? $urandom_range(10, 48) : $urandom_range(0, 9);
         push_chunk(types[i], sz);
      end
      if ($urandom_range(99) < 15) begin
         cut = $urandom_range(1, file_q.size());
         while (file_q.size() > cut) void'(file_q.pop_back());
      end
   endtask

   // Main sequence: reset, directed files, then four phases of random files under different idle and stall rates.
   initial begin
      int beats_sent;
      int ph;
      board = new();
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Short files with the extreme byte values.
      file_q.delete();
      file_q = {file_q, 8'hFF};
      send_file();
      file_q.delete();
      file_q = {file_q, 8'h00};
      send_file();
      // A file that holds a good header and nothing else.
      file_q.delete();
      push_word(GLB_MAGIC);
      push_word(32'(GLB_VERSION));
      push_word(32'd12);
      send_file();
      // A complete header with the wrong version.
      file_q.delete();
      push_word(GLB_MAGIC);
      push_word(32'd3);
      push_word(32'd12);
      send_file();

      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               tx_idle_pct = 0;
               rx_stall_pct = 0;
            end
            1: begin
               tx_idle_pct = 58;
               rx_stall_pct = 0;
            end
            2: begin
               tx_idle_pct = 0;
               rx_stall_pct = 58;
            end
            default: begin
               tx_idle_pct = 38;
               rx_stall_pct = 38;
            end
         endcase
         // Let the block fill up behind a receiver that holds off.
         if (ph == 0 || ph == 2) hold_request = 1'b1;
         beats_sent = 0;
         while (beats_sent < PHASE_BEATS) begin
            build_random_file();
            beats_sent += file_q.size();
            send_file();
         end
         pause_for_drain();
      end

      repeat (8) @(negedge clock);
      if (board.pending_count() != 0) board.report("results still outstanding at end of run");
      if (board.errors == 0) begin
         $display("[glb_container_deframer_unit] OK");
      end else begin
         $display("[glb_container_deframer_unit] ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
sv/gcd_pkg.sv
sv/gcd_parse.sv
sv/gcd_out_reg.sv
sv/glb_container_deframer_unit.sv
tb/glb_container_deframer_unit_tb.sv
